[hdl/rle_marker_word_encoder_top_assert.svh]
// Assertion macros shared by the checker of the word encoder.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef RLE_MARKER_WORD_ENCODER_TOP_ASSERT_SVH
`define RLE_MARKER_WORD_ENCODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLEMW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLEMW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rlemw_pkg.sv]
`timescale 1ns / 1ps

package rlemw_pkg;

	// default width of the emitted run count
	localparam int unsigned COUNT_WIDTH_DEF = 32;
	// command queue depth between front and back
	localparam int unsigned CMD_DEPTH = 4;

	localparam logic [63:0] RLE_MARKER  = 64'h0000_0000_E3A4_9A3D;
	localparam logic [31:0] LITERAL_MAX = 32'd3;

	// result slots of one command, emitted from low to high
	localparam int unsigned NUM_SLOTS = 7;
	localparam int unsigned SLOT_HDR  = 0;
	localparam int unsigned SLOT_OLD0 = 1;
	localparam int unsigned SLOT_OLD1 = 2;
	localparam int unsigned SLOT_OLD2 = 3;
	localparam int unsigned SLOT_END0 = 4;
	localparam int unsigned SLOT_END1 = 5;
	localparam int unsigned SLOT_END2 = 6;

	// one run to flush: marker/symbol/count triple or literal copies
	typedef struct packed {
		logic [63:0] symbol;
		logic [31:0] count;
		logic        triple;
	} rlemw_flush_t;

	// one classified request, handed from front to back
	typedef struct packed {
		logic [NUM_SLOTS-1:0] slot_mask;
		logic [31:0]          header;
		rlemw_flush_t         f_old;
		rlemw_flush_t         f_end;
		logic                 chunk_last;
	} rlemw_cmd_t;

endpackage

[hdl/rlemw_fifo.sv]
`timescale 1ns / 1ps

module rlemw_fifo #(
	parameter int unsigned DEPTH = rlemw_pkg::CMD_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rlemw_pkg::rlemw_cmd_t wr_cmd,
	input  logic                 pop,
	output rlemw_pkg::rlemw_cmd_t rd_cmd,
	output logic                 empty,
	output logic                 full
);
	import rlemw_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	rlemw_cmd_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign rd_cmd = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

[hdl/rlemw_front.sv]
`timescale 1ns / 1ps

module rlemw_front #(
	parameter int unsigned COUNT_WIDTH = rlemw_pkg::COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [31:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [63:0]           in_word,
	input  logic                  q_full,
	output logic                  push,
	output rlemw_pkg::rlemw_cmd_t cmd
);
	import rlemw_pkg::*;

	// run length never exceeds what the count field can carry
	localparam int unsigned RL_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

	logic [31:0]     chunk_words_q;
	logic [63:0]     run_symbol_q;
	logic [RL_W-1:0] run_length_q;
	logic [31:0]     words_taken_q;

	logic            accept;
	logic [31:0]     len;
	logic            first;
	logic            extend;
	logic            last;
	logic            flush_old;
	logic [63:0]     new_sym;
	logic [RL_W-1:0] new_len;
	logic            old_triple;
	logic            end_triple;

	// result slots used by one flushed run
	function automatic logic [2:0] run_slots(input logic triple, input logic [RL_W-1:0] n);
		logic [2:0] s;
		if (triple) begin
			s = 3'b111;
		end else begin
			s = {n > RL_W'(2), n > RL_W'(1), n > RL_W'(0)};
		end
		return s;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// classify the incoming word against the open run
	always_comb begin
		len        = (chunk_words_q == '0) ? 32'd1 : chunk_words_q;
		first      = (words_taken_q == '0);
		extend     = !first && (in_word == run_symbol_q) && (run_length_q != '1);
		last       = ({1'b0, words_taken_q} + 33'd1) >= {1'b0, len};
		flush_old  = !first && !extend;
		new_sym    = extend ? run_symbol_q : in_word;
		new_len    = extend ? run_length_q + RL_W'(1) : RL_W'(1);
		old_triple = (run_symbol_q == RLE_MARKER) || (run_length_q > RL_W'(LITERAL_MAX));
		end_triple = (new_sym == RLE_MARKER) || (new_len > RL_W'(LITERAL_MAX));

		cmd.slot_mask    = {last ? run_slots(end_triple, new_len) : 3'b000,
		                    flush_old ? run_slots(old_triple, run_length_q) : 3'b000,
		                    first};
		cmd.header       = len;
		cmd.f_old.symbol = run_symbol_q;
		cmd.f_old.count  = 32'(run_length_q);
		cmd.f_old.triple = old_triple;
		cmd.f_end.symbol = new_sym;
		cmd.f_end.count  = 32'(new_len);
		cmd.f_end.triple = end_triple;
		cmd.chunk_last   = last;
	end

	// a word that only extends the run sends nothing
	assign push = accept && (cmd.slot_mask != '0);

	// run state and chunk length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_words_q <= 32'd1;
			run_symbol_q  <= '0;
			run_length_q  <= '0;
			words_taken_q <= '0;
		end else begin
			if (cfg_we) begin
				chunk_words_q <= cfg_wdata;
			end
			if (accept) begin
				run_symbol_q  <= new_sym;
				run_length_q  <= last ? '0 : new_len;
				words_taken_q <= last ? '0 : words_taken_q + 32'd1;
			end
		end
	end

endmodule

[hdl/rlemw_back.sv]
`timescale 1ns / 1ps

module rlemw_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  rlemw_pkg::rlemw_cmd_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           out_word,
	output logic                  out_item_last,
	output logic                  out_chunk_end
);
	import rlemw_pkg::*;

	logic [NUM_SLOTS-1:0] done_q;
	logic                 out_valid_q;
	logic [63:0]          out_word_q;
	logic                 item_last_q;
	logic                 chunk_end_q;

	logic [NUM_SLOTS-1:0] rem;
	logic [NUM_SLOTS-1:0] low;
	logic                 final_w;
	logic                 load;
	logic [63:0]          sel_word;

	// next slot of the head request, lowest first
	assign rem     = head.slot_mask & ~done_q;
	assign low     = rem & (~rem + NUM_SLOTS'(1));
	assign final_w = ((rem & ~low) == '0);
	assign load    = head_valid && (!out_valid_q || out_ready);
	assign pop     = load && final_w;

	// word carried by the selected slot
	always_comb begin
		priority if (low[SLOT_HDR]) begin
			sel_word = {32'd0, head.header};
		end else if (low[SLOT_OLD0]) begin
			sel_word = head.f_old.triple ? RLE_MARKER : head.f_old.symbol;
		end else if (low[SLOT_OLD1]) begin
			sel_word = head.f_old.symbol;
		end else if (low[SLOT_OLD2]) begin
			sel_word = head.f_old.triple ? {32'd0, head.f_old.count} : head.f_old.symbol;
		end else if (low[SLOT_END0]) begin
			sel_word = head.f_end.triple ? RLE_MARKER : head.f_end.symbol;
		end else if (low[SLOT_END1]) begin
			sel_word = head.f_end.symbol;
		end else if (low[SLOT_END2]) begin
			sel_word = head.f_end.triple ? {32'd0, head.f_end.count} : head.f_end.symbol;
		end else begin
			sel_word = '0;
		end
	end

	// slot progress and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			done_q      <= final_w ? '0 : (done_q | low);
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q  <= sel_word;
			item_last_q <= final_w;
			chunk_end_q <= final_w && head.chunk_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_word      = out_word_q;
	assign out_item_last = item_last_q;
	assign out_chunk_end = chunk_end_q;

endmodule

[hdl/rle_marker_word_encoder_top.sv]
`timescale 1ns / 1ps

// Run-length encoder for chunks of 64-bit words with an escape marker. A new
// input word is taken every cycle while the command queue between front and
// back has room (CMD_DEPTH entries); the front compares it with the open run
// and queues a request of up to six result words. The back sends one result
// word per cycle while the output is ready, so the sustained rate is one input
// word per cycle as long as words average no more than one result each; bursts
// stall the input once the queue fills. The first result of a word passes the
// command queue and the output register. The first word of a chunk yields a
// header with the chunk length (0 counts as 1); runs of four or more, or of the
// marker word, are sent as marker, symbol, count, shorter runs as literal
// copies. m_tuser marks the last result of each input word, m_tlast the last
// result of a chunk. A chunk length written mid-chunk takes effect at once.
module rle_marker_word_encoder_top #(
	parameter int unsigned COUNT_WIDTH = rlemw_pkg::COUNT_WIDTH_DEF,
	parameter int unsigned CMD_DEPTH   = rlemw_pkg::CMD_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,  // chunk_words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // [63:0] word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // [63:0] out_word
	output logic [0:0]  m_tuser,    // [0] item_last
	output logic        m_tlast     // chunk_end
);
	import rlemw_pkg::*;

	rlemw_cmd_t wr_cmd;
	rlemw_cmd_t rd_cmd;
	logic       push;
	logic       pop;
	logic       q_empty;
	logic       q_full;

	rlemw_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_word  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.cmd      (wr_cmd)
	);

	rlemw_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(wr_cmd),
		.pop   (pop),
		.rd_cmd(rd_cmd),
		.empty (q_empty),
		.full  (q_full)
	);

	rlemw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!q_empty),
		.head         (rd_cmd),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_word     (m_tdata),
		.out_item_last(m_tuser[0]),
		.out_chunk_end(m_tlast)
	);

endmodule

[hdl/rlemw_checker.sv]
`timescale 1ns / 1ps

`include "rle_marker_word_encoder_top_assert.svh"

module rlemw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result holds its contents
	`RLEMW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// a chunk ends only on the last result of a word
	`RLEMW_ASSERT_SAME(a_end_is_item_last, m_tvalid && m_tlast, m_tuser[0], "chunk end without item last")

	// input stalls only while results are waiting on the output
	`RLEMW_ASSERT_SAME(a_stall_has_output, !s_tready, m_tvalid, "input stalled with idle output")

endmodule

bind rle_marker_word_encoder_top rlemw_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

[tb/tb_rle_marker_word_encoder_top.sv]
`timescale 1ns / 1ps

module tb_rle_marker_word_encoder_top;
	import rlemw_pkg::*;

	localparam int unsigned RANDOM_WORDS  = 450;
	// spare idle cycles after the last result before a configuration write
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam logic [31:0] COUNT_CAP     = 32'hFFFF_FFFF;  // COUNT_WIDTH of 32

	typedef struct packed {
		logic [63:0] data;
		logic        item_last;
		logic        chunk_end;
	} enc_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;     // [63:0] word
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;          // [63:0] out_word
	logic [0:0]  m_tuser;          // [0] item_last
	logic        m_tlast;          // chunk_end

	// predictor state
	logic [63:0] run_sym;
	logic [31:0] run_len;
	logic [31:0] words_taken;
	logic [31:0] chunk_len;

	enc_result_t encoded_q[$];
	enc_result_t burst_q[$];
	logic [63:0] sym_pool[4];
	int unsigned errors;
	int unsigned words_sent;
	int unsigned stall_cycles;
	bit          steady;

	rle_marker_word_encoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ---------------------------------------------------------------- predictor

	task automatic put_word(input logic [63:0] value);
		enc_result_t r;
		r.data      = value;
		r.item_last = 1'b0;
		r.chunk_end = 1'b0;
		burst_q = {burst_q, r};
	endtask

	// long runs and marker runs go out as marker, symbol, count, shorter runs as literal copies
	task automatic flush_run();
		if (run_sym == RLE_MARKER || run_len > LITERAL_MAX) begin
			put_word(RLE_MARKER);
			put_word(run_sym);
			put_word({32'd0, run_len});
		end else begin
			for (int unsigned k = 0; k < run_len; k++)
				put_word(run_sym);
		end
	endtask

	task automatic encode_word(input logic [63:0] w);
		logic [31:0] len;
		logic        last;
		enc_result_t r;
		burst_q.delete();
		len = (chunk_len == 32'd0) ? 32'd1 : chunk_len;
		if (words_taken == 32'd0) begin
			put_word({32'd0, len});
			run_sym = w;
			run_len = 32'd1;
		end else if (w == run_sym && run_len < COUNT_CAP) begin
			run_len = run_len + 32'd1;
		end else begin
			flush_run();
			run_sym = w;
			run_len = 32'd1;
		end
		last = ({1'b0, words_taken} + 33'd1) >= {1'b0, len};
		if (last) begin
			flush_run();
			words_taken = 32'd0;
			run_len = 32'd0;
		end else begin
			words_taken = words_taken + 32'd1;
		end
		if (burst_q.size() > 0) begin
			r = burst_q.pop_back();
			r.item_last = 1'b1;
			r.chunk_end = last;
			burst_q = {burst_q, r};
		end
		encoded_q = {encoded_q, burst_q};
		burst_q.delete();
	endtask

	// ---------------------------------------------------------------- drivers

	task automatic send_word(input logic [63:0] w);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 35) begin
			s_tvalid = 1'b0;
			s_tdata  = {$urandom, $urandom};
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = w;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		encode_word(w);
		words_sent++;
	endtask

	// stop sending and let every expected result drain
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (encoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_chunk_words(input logic [31:0] value);
		drain();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(posedge clk);
		chunk_len = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		cfg_wdata = {$urandom};
	endtask

	function automatic logic [63:0] pick_symbol();
		case ($urandom_range(9))
			0: return RLE_MARKER;
			1: return '0;
			2: return '1;
			3, 4, 5, 6: return sym_pool[$urandom_range(3)];
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// ---------------------------------------------------------------- receiver

	always @(negedge clk) begin
		if (arst_n)
			m_tready = steady || ($urandom_range(99) >= 35);
	end

	always @(posedge clk) begin
		enc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (encoded_q.size() == 0) begin
				$display("%0t: unexpected result, got data %h item_last %b chunk_end %b",
					$time, m_tdata, m_tuser[0], m_tlast);
				errors++;
			end else begin
				want = encoded_q.pop_front();
				if (m_tdata !== want.data) begin
					$display("%0t: data expected %h, got %h", $time, want.data, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== want.item_last) begin
					$display("%0t: item_last expected %b, got %b",
						$time, want.item_last, m_tuser[0]);
					errors++;
				end
				if (m_tlast !== want.chunk_end) begin
					$display("%0t: chunk_end expected %b, got %b",
						$time, want.chunk_end, m_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, stall_cycles);
				$display("rle_marker_word_encoder_top test failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// reset length of one: every word is header plus one literal
	task automatic test_default_length();
		send_word(64'd0);
		send_word('1);
	endtask

	// length 0 behaves as 1
	task automatic test_zero_length();
		write_chunk_words(32'd0);
		send_word(64'h8000_0000_0000_0001);
	endtask

	// long run, single literal, marker run, short run; then the six-result word
	task automatic test_run_forms();
		write_chunk_words(32'd8);
		repeat (4) send_word(64'h5A5A_A5A5_0F0F_F0F0);
		send_word(64'h0123_4567_89AB_CDEF);
		send_word(RLE_MARKER);
		repeat (2) send_word(64'hFEDC_BA98_7654_3210);
		write_chunk_words(32'd5);
		repeat (4) send_word(64'h0000_0000_E3A4_9A3C);
		send_word(RLE_MARKER);
	endtask

	// shrinking the length below the words taken ends the chunk on the next word
	task automatic test_length_change();
		write_chunk_words(32'd10);
		repeat (2) send_word(64'h1111_2222_3333_4444);
		send_word(64'h5555_6666_7777_8888);
		send_word(64'h9999_AAAA_BBBB_CCCC);
		write_chunk_words(32'd3);
		send_word(64'hDDDD_EEEE_FFFF_0000);
		write_chunk_words(32'hFFFF_FFFF);
		repeat (3) send_word(RLE_MARKER);
		write_chunk_words(32'd2);
		send_word(RLE_MARKER);
	endtask

	// runs of random symbols over a mix of chunk lengths, phases end mid-chunk
	task automatic test_random_chunks();
		int unsigned start;
		int unsigned phase;
		int unsigned goal;
		int unsigned done;
		int unsigned rl;
		logic [31:0] len;
		logic [63:0] sym;
		start = words_sent;
		phase = 0;
		while (words_sent - start < RANDOM_WORDS) begin
			case ($urandom_range(19))
				0, 1, 2: len = 32'd0;
				3, 4: len = 32'd1;
				5, 6, 7: len = $urandom_range(40, 13);
				default: len = $urandom_range(12, 2);
			endcase
			write_chunk_words(len);
			sym_pool[0] = RLE_MARKER ^ (64'd1 << $urandom_range(63));
			for (int i = 1; i < 4; i++)
				sym_pool[i] = {$urandom, $urandom};
			steady = (phase == 3);
			// the phase with no idling runs long
			goal = steady ? 120 : $urandom_range(40, 8);
			done = 0;
			while (done < goal) begin
				sym = pick_symbol();
				rl = ($urandom_range(3) == 0) ? $urandom_range(9, 4) : $urandom_range(3, 1);
				for (int unsigned k = 0; k < rl && done < goal; k++) begin
					send_word(sym);
					done++;
				end
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		errors = 0;
		words_sent = 0;
		stall_cycles = 0;
		steady = 1'b0;
		run_sym = '0;
		run_len = '0;
		words_taken = '0;
		chunk_len = 32'd1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_length();
		test_zero_length();
		test_run_forms();
		test_length_change();
		test_random_chunks();

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("rle_marker_word_encoder_top test passed");
		end else begin
			$display("rle_marker_word_encoder_top test failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/rlemw_pkg.sv
hdl/rlemw_fifo.sv
hdl/rlemw_front.sv
hdl/rlemw_back.sv
hdl/rle_marker_word_encoder_top.sv
hdl/rlemw_checker.sv
tb/tb_rle_marker_word_encoder_top.sv
